/* sv/dmsp_pkg.sv */
package dmsp_pkg;

    // Law constants.
    localparam int SPEED_LIMIT    = 500;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int SPEED_SCALE    = 13;
    localparam int INTEG_LIMIT    = 100;

    // Datapath widths.
    localparam int GAIN_W   = 16;
    localparam int TARGET_W = 11;
    localparam int SPEED_W  = 16;
    localparam int COUNT_W  = 12;
    localparam int ERR_W    = 16;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int SUM_W    = GAIN_W + DERIV_W + 2;
    localparam int DRIVE_W  = 16;
    localparam int NUM_SIDES = 2;

    localparam int DRIVE_MAX = (1 << (DRIVE_W - 1)) - 1;
    localparam int DRIVE_MIN = -(1 << (DRIVE_W - 1));

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic {
        SIDE_RIGHT = 1'b0,
        SIDE_LEFT  = 1'b1
    } side_t;

    typedef enum logic [1:0] {
        REG_P_GAIN = 2'd0,
        REG_D_GAIN = 2'd1,
        REG_I_GAIN = 2'd2,
        REG_NONE   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] p_gain;
        logic signed [GAIN_W-1:0] d_gain;
        logic signed [GAIN_W-1:0] i_gain;
    } gains_t;

    // Per-side controller state as read for one item.
    typedef struct packed {
        logic signed [TARGET_W-1:0] target;
        logic signed [ERR_W-1:0]    prev_err;
        logic signed [ERR_W-1:0]    integ;
    } side_state_t;

    // State update produced by the control law for one item.
    typedef struct packed {
        logic                       set_we;
        logic                       tick_we;
        logic                       side;
        logic signed [TARGET_W-1:0] target;
        logic signed [ERR_W-1:0]    err;
        logic signed [ERR_W-1:0]    integ;
    } state_update_t;

endpackage

/* sv/dmsp_state.sv */
module dmsp_state
    import dmsp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic          commit,
    input  state_update_t upd,
    input  logic          rd_side,
    output side_state_t   rd
);

    logic signed [TARGET_W-1:0] target_reg [NUM_SIDES];
    logic signed [ERR_W-1:0]    prev_err_reg [NUM_SIDES];
    logic signed [ERR_W-1:0]    integ_reg [NUM_SIDES];

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < NUM_SIDES; i++) begin
                target_reg[i]   <= '0;
                prev_err_reg[i] <= '0;
                integ_reg[i]    <= '0;
            end
        end else if (commit) begin
            if (upd.set_we) begin
                target_reg[upd.side] <= upd.target;
            end
            if (upd.tick_we) begin
                prev_err_reg[upd.side] <= upd.err;
                integ_reg[upd.side]    <= upd.integ;
            end
        end
    end

    assign rd.target   = target_reg[rd_side];
    assign rd.prev_err = prev_err_reg[rd_side];
    assign rd.integ    = integ_reg[rd_side];

endmodule

/* sv/dmsp_law.sv */
module dmsp_law
    import dmsp_pkg::*;
(
    input  logic                      op,
    input  logic                      side,
    input  logic signed [15:0]        target_speed,
    input  logic signed [COUNT_W-1:0] encoder_count,
    input  gains_t                    gains,
    input  side_state_t               st,
    output state_update_t             upd,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      drive_saturated
);

    logic signed [TARGET_W-1:0] target_clamped;
    logic signed [SPEED_W:0]    speed;
    logic signed [ERR_W:0]      err_wide;
    logic signed [ERR_W-1:0]    err;
    logic signed [ERR_W:0]      integ_wide;
    logic signed [ERR_W-1:0]    integ;
    logic signed [DERIV_W-1:0]  deriv;
    logic signed [31:0]         p_term;
    logic signed [32:0]         d_term;
    logic signed [31:0]         i_term;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_biased;
    logic signed [SUM_W-1:0]    corr;
    logic signed [SUM_W:0]      drive_wide;

    localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

    // Target clamp for set items.
    always_comb begin
        if (int'(target_speed) > SPEED_LIMIT) begin
            target_clamped = TARGET_W'(SPEED_LIMIT);
        end else if (int'(target_speed) < -SPEED_LIMIT) begin
            target_clamped = TARGET_W'(-SPEED_LIMIT);
        end else begin
            target_clamped = TARGET_W'(target_speed);
        end
    end

    always_comb begin
        speed = (SPEED_W + 1)'(encoder_count) * (SPEED_W + 1)'(SPEED_SCALE);
        if (side == SIDE_LEFT) begin
            speed = -speed;
        end
        err_wide = (ERR_W + 1)'(st.target) - (ERR_W + 1)'(speed);
        err      = ERR_W'(err_wide);

        // The integral only accumulates while it is small; otherwise it resets.
        if (int'(st.integ) > -INTEG_LIMIT && int'(st.integ) < INTEG_LIMIT) begin
            integ_wide = (ERR_W + 1)'(st.integ) + (ERR_W + 1)'(err);
        end else begin
            integ_wide = '0;
        end
        integ = ERR_W'(integ_wide);

        deriv  = DERIV_W'(err) - DERIV_W'(st.prev_err);
        p_term = 32'(gains.p_gain) * 32'(err);
        d_term = 33'(gains.d_gain) * 33'(deriv);
        i_term = 32'(gains.i_gain) * 32'(integ);
        sum    = SUM_W'(p_term) + SUM_W'(d_term) + SUM_W'(i_term);

        // Divide by the fraction scale, rounding toward zero.
        sum_biased = sum[SUM_W-1] ? (sum + FRAC_MASK) : sum;
        corr       = sum_biased >>> GAIN_FRAC_BITS;
        drive_wide = (SUM_W + 1)'(st.target) + (SUM_W + 1)'(corr);

        if (drive_wide > (SUM_W + 1)'(DRIVE_MAX)) begin
            drive           = DRIVE_W'(DRIVE_MAX);
            drive_saturated = 1'b1;
        end else if (drive_wide < (SUM_W + 1)'(DRIVE_MIN)) begin
            drive           = DRIVE_W'(DRIVE_MIN);
            drive_saturated = 1'b1;
        end else begin
            drive           = DRIVE_W'(drive_wide);
            drive_saturated = 1'b0;
        end
    end

    assign upd.set_we  = (op == OP_SET);
    assign upd.tick_we = (op == OP_TICK);
    assign upd.side    = side;
    assign upd.target  = target_clamped;
    assign upd.err     = err;
    assign upd.integ   = integ;

endmodule

/* sv/dual_motor_speed_pid.sv */
// A tick transaction is taken into the input register, then its result is loaded into the
// result register and offered; a set transaction gives no result.
// Throughput: one transaction per clock unless a tick waits on a full, stalled result register,
// set by the single compute stage that reads and writes the per-side state in the same cycle.
// Reset (aresetn low, synchronous) clears gains, per-side state and all valid flags.
module dual_motor_speed_pid
    import dmsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] target_speed, [27:16] encoder_count, rest zero
    input  logic [1:0]  s_tuser,   // [0] operation, [1] side

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] drive
    output logic [1:0]  m_tuser,   // [0] out_side, [1] drive_saturated

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Input register stage. The valid flag is control state; the payload
    // needs no reset because it is only looked at while valid is set.
    logic                      s1_valid_reg;
    logic                      s1_op_reg;
    logic                      s1_side_reg;
    logic signed [15:0]        s1_target_reg;
    logic signed [COUNT_W-1:0] s1_count_reg;

    // Result register stage.
    logic                      m_valid_reg;
    logic                      m_side_reg;
    logic signed [DRIVE_W-1:0] m_drive_reg;
    logic                      m_sat_reg;

    gains_t gains_reg;

    logic                      out_ready;
    logic                      s1_go;
    logic                      s1_result;
    logic                      cfg_write;
    logic                      gain_write;
    side_state_t               st_rd;
    state_update_t             upd;
    logic signed [DRIVE_W-1:0] drive;
    logic                      drive_saturated;

    // The user must issue configuration writes only while the block is idle; the block does
    // not enforce this, and the port can always take them.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Only the three defined registers count; a write to the unused index is dropped
    // and leaves the state alone.
    always_comb begin
        case (reg_index_t'(cfg_index))
            REG_P_GAIN, REG_D_GAIN, REG_I_GAIN: gain_write = cfg_write;
            default:                            gain_write = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
        end else if (gain_write) begin
            case (reg_index_t'(cfg_index))
                REG_P_GAIN: gains_reg.p_gain <= cfg_data;
                REG_D_GAIN: gains_reg.d_gain <= cfg_data;
                REG_I_GAIN: gains_reg.i_gain <= cfg_data;
                default:    gains_reg        <= gains_reg;
            endcase
        end
    end

    // The result register can take a new value when it is empty or being drained.
    // A set transaction never needs the result register, so it always moves on.
    assign out_ready = !m_valid_reg || m_tready;
    assign s1_result = s1_valid_reg && (s1_op_reg == OP_TICK);
    assign s1_go     = s1_valid_reg && ((s1_op_reg == OP_SET) || out_ready);
    assign s_tready  = !s1_valid_reg || s1_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_op_reg     <= s_tuser[0];
            s1_side_reg   <= s_tuser[1];
            s1_target_reg <= s_tdata[15:0];
            s1_count_reg  <= s_tdata[27:16];
        end
    end

    // Per-side target, previous error and integral. Any gain write clears them.
    dmsp_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (gain_write),
        .commit  (s1_go),
        .upd     (upd),
        .rd_side (s1_side_reg),
        .rd      (st_rd)
    );

    // Control law: error, integral rule, three gain products, scaling and
    // saturation, all between the input and result registers.
    dmsp_law u_law (
        .op              (s1_op_reg),
        .side            (s1_side_reg),
        .target_speed    (s1_target_reg),
        .encoder_count   (s1_count_reg),
        .gains           (gains_reg),
        .st              (st_rd),
        .upd             (upd),
        .drive           (drive),
        .drive_saturated (drive_saturated)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s1_go && s1_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_result) begin
            m_side_reg  <= s1_side_reg;
            m_drive_reg <= drive;
            m_sat_reg   <= drive_saturated;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_drive_reg;
    assign m_tuser  = {m_sat_reg, m_side_reg};

endmodule

/* sv/dmsp_checker.sv */
module dmsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result transaction stays offered.
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result transaction keeps its payload.
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // A saturated drive sits on one of the two rails.
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 16'h7fff || m_tdata == 16'h8000)
        else $error("saturation flag set on a value off the rails");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind dual_motor_speed_pid dmsp_checker u_checker (.*);

/* tb/tb_top.sv */
module tb_top;
    import dmsp_pkg::*;

    // Cycles without any transaction on any channel before the run is declared hung.
    // The slowest correct stretch is a sender gap plus a receiver stall plus the pipeline.
    localparam int QUIET_LIMIT = 2000;
    // A set transaction leaves no result behind, so after the last drive result
    // has come we still let the two-stage pipeline empty before touching a gain.
    localparam int SETTLE_CYCLES = 4;

    // One command as it travels on the input stream.
    typedef struct packed {
        op_t                  op;
        side_t                side;
        logic signed [15:0]   target;
        logic signed [11:0]   count;
    } pid_cmd_t;

    // One drive result as the block should report it.
    typedef struct {
        side_t       side;
        logic [15:0] drive;
        logic        sat;
    } drive_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [15:0] target_speed, [27:16] encoder_count
    logic [1:0]  s_tuser   = '0;    // [0] operation, [1] side

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [15:0] drive
    logic [1:0]  m_tuser;           // [0] out_side, [1] drive_saturated

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_NONE;
    logic [15:0] cfg_data  = '0;

    // Commands waiting to be driven and drive results waiting to be seen.
    pid_cmd_t      cmd_q[$];
    drive_result_t drive_q[$];

    int cmds_queued  = 0;
    int cmds_taken   = 0;
    int gain_writes  = 0;
    int err_count    = 0;
    int quiet_cycles = 0;
    int src_gap      = 0;
    int sink_stall   = 0;
    bit idle_en      = 1'b1;
    bit s_fire       = 1'b0;

    // Our own copy of the control law state: shared gains and per-side memories.
    int p_gain_m = 0;
    int d_gain_m = 0;
    int i_gain_m = 0;
    int target_mem[NUM_SIDES]   = '{default: 0};
    int prev_err_mem[NUM_SIDES] = '{default: 0};
    int integ_mem[NUM_SIDES]    = '{default: 0};

    dual_motor_speed_pid i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Runs one accepted command through the speed law. A set only updates the
    // clamped target; a tick updates the integral and the previous error of its
    // side and queues the drive it should produce.
    function automatic void predict_drive(input op_t op, input side_t sd,
                                          input logic signed [15:0] tgt_in,
                                          input logic signed [11:0] cnt);
        int            tgt;
        int            spd;
        int            err;
        int            integ;
        longint        sum;
        longint        drv;
        drive_result_t r;
        if (op == OP_SET) begin
            tgt = tgt_in;
            if (tgt > SPEED_LIMIT)
                tgt = SPEED_LIMIT;
            else if (tgt < -SPEED_LIMIT)
                tgt = -SPEED_LIMIT;
            target_mem[int'(sd)] = tgt;
            return;
        end
        tgt = target_mem[int'(sd)];
        // The left encoder counts the other way round.
        spd = SPEED_SCALE * int'(cnt);
        if (sd == SIDE_LEFT)
            spd = -spd;
        err = tgt - spd;
        // Anti-windup: once the integral has reached the limit it is dumped
        // instead of taking the new error.
        integ = integ_mem[int'(sd)];
        if (integ > -INTEG_LIMIT && integ < INTEG_LIMIT)
            integ = integ + err;
        else
            integ = 0;
        sum = longint'(p_gain_m) * err
            + longint'(d_gain_m) * (err - prev_err_mem[int'(sd)])
            + longint'(i_gain_m) * integ;
        // Signed division truncates toward zero, unlike an arithmetic shift.
        drv = tgt + sum / (longint'(1) << GAIN_FRAC_BITS);
        r.sat = 1'b0;
        if (drv > DRIVE_MAX) begin
            drv   = DRIVE_MAX;
            r.sat = 1'b1;
        end else if (drv < DRIVE_MIN) begin
            drv   = DRIVE_MIN;
            r.sat = 1'b1;
        end
        r.side  = sd;
        r.drive = drv[15:0];
        drive_q.push_back(r);
        integ_mem[int'(sd)]    = integ;
        prev_err_mem[int'(sd)] = err;
    endfunction

    // Monitor: everything is sampled at the rising edge. Input transactions feed
    // the predictor, result transactions are checked against the oldest expected
    // drive, and gain writes update our copy of the gains.
    always @(posedge aclk) begin : monitor
        drive_result_t exp_r;
        s_fire = ((s_tvalid && s_tready) === 1'b1);
        if ((m_tvalid && m_tready) === 1'b1) begin
            if (drive_q.size() == 0) begin
                $error("result with nothing expected: side %0d drive %0d",
                       m_tuser[0], $signed(m_tdata));
                err_count++;
            end else begin
                exp_r = drive_q.pop_front();
                if (m_tuser[0] !== exp_r.side) begin
                    $error("out_side: expected %0d, actual %0d", exp_r.side, m_tuser[0]);
                    err_count++;
                end
                if (m_tdata !== exp_r.drive) begin
                    $error("drive: expected %0d, actual %0d",
                           $signed(exp_r.drive), $signed(m_tdata));
                    err_count++;
                end
                if (m_tuser[1] !== exp_r.sat) begin
                    $error("drive_saturated: expected %0d, actual %0d",
                           exp_r.sat, m_tuser[1]);
                    err_count++;
                end
            end
        end
        if (s_fire) begin
            cmds_taken++;
            predict_drive(op_t'(s_tuser[0]), side_t'(s_tuser[1]),
                          s_tdata[15:0], s_tdata[27:16]);
        end
        if ((cfg_valid && cfg_ready) === 1'b1) begin
            gain_writes++;
            case (reg_index_t'(cfg_index))
                REG_P_GAIN: p_gain_m = $signed(cfg_data);
                REG_D_GAIN: d_gain_m = $signed(cfg_data);
                REG_I_GAIN: i_gain_m = $signed(cfg_data);
                default: ;
            endcase
            // Any real gain write restarts both loops from scratch; a write to
            // an unused index leaves everything as it was.
            if (reg_index_t'(cfg_index) != REG_NONE) begin
                foreach (target_mem[k]) begin
                    target_mem[k]   = 0;
                    prev_err_mem[k] = 0;
                    integ_mem[k]    = 0;
                end
            end
        end
    end

    // Input driver: changes the stream at the falling edge. A command stays on
    // the bus until it is accepted; between commands it may insert a random gap.
    always @(negedge aclk) begin : cmd_driver
        pid_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                s_tdata  <= {4'b0, c.count, c.target};
                s_tuser  <= {c.side, c.op};
                s_tvalid <= 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 11);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: ready drops in random bursts.
    always @(negedge aclk) begin : sink_pacing
        if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_en && $urandom_range(0, 9) == 0)
                sink_stall = $urandom_range(1, 11);
        end
    end

    // Watchdog: a hung handshake on any channel ends the run.
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) === 1'b1 || (m_tvalid && m_tready) === 1'b1 ||
            (cfg_valid && cfg_ready) === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_cmd(input op_t op, input side_t sd, input int tgt, input int cnt);
        pid_cmd_t c;
        c.op     = op;
        c.side   = sd;
        c.target = 16'(tgt);
        c.count  = 12'(cnt);
        cmd_q.push_back(c);
        cmds_queued++;
    endtask

    // Waits until every queued command has been taken and every expected drive
    // has arrived, then lets the pipeline drain of set transactions.
    task automatic wait_idle();
        @(negedge aclk);
        while (cmds_taken != cmds_queued || drive_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_gain(input reg_index_t idx, input logic [15:0] val);
        int want;
        want = gain_writes + 1;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (gain_writes != want)
            @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly modest gains so the drive stays in range and the law is visible,
    // with full-range values and the extremes mixed in.
    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            default: return 16'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    // Random commands. Small targets and counts keep errors near the
    // integral limit so the windup logic gets exercised; full-range values and
    // clamp corners are mixed in. Ignored fields carry random values too.
    task automatic push_random(input int n);
        int    tgt;
        int    cnt;
        op_t   op;
        side_t sd;
        for (int k = 0; k < n; k++) begin
            op = $urandom_range(0, 1) ? OP_TICK : OP_SET;
            sd = $urandom_range(0, 1) ? SIDE_LEFT : SIDE_RIGHT;
            case ($urandom_range(0, 4))
                0: tgt = $urandom;
                1: begin
                    case ($urandom_range(0, 5))
                        0: tgt = SPEED_LIMIT;
                        1: tgt = -SPEED_LIMIT;
                        2: tgt = SPEED_LIMIT + 1;
                        3: tgt = -SPEED_LIMIT - 1;
                        4: tgt = 32767;
                        default: tgt = -32768;
                    endcase
                end
                default: tgt = int'($urandom_range(0, 1400)) - 700;
            endcase
            if ($urandom_range(0, 9) < 7)
                cnt = int'($urandom_range(0, 80)) - 40;
            else
                cnt = $urandom;
            push_cmd(op, sd, tgt, cnt);
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // With the reset gains the drive is just the clamped target.
        push_cmd(OP_SET,  SIDE_RIGHT, 501, 0);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, 0);
        push_cmd(OP_SET,  SIDE_LEFT, -32768, 0);
        push_cmd(OP_TICK, SIDE_LEFT, 0, 5);
        wait_idle();

        // Extreme gains push the drive into saturation, with the largest encoder counts
        // in both directions on the left side and the most negative one on the right.
        write_gain(REG_P_GAIN, 16'h7FFF);
        write_gain(REG_D_GAIN, 16'h8000);
        write_gain(REG_I_GAIN, 16'h7FFF);
        push_cmd(OP_SET,  SIDE_RIGHT, 32767, 0);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, -2048);
        push_cmd(OP_TICK, SIDE_LEFT, 0, 2047);
        push_cmd(OP_SET,  SIDE_LEFT, -501, 0);
        push_cmd(OP_TICK, SIDE_LEFT, 0, -2048);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, 1);
        wait_idle();

        // Unit proportional and integral gain make the integral visible in the
        // drive: reaching exactly plus or minus the limit, then being dumped.
        write_gain(REG_P_GAIN, 16'sd256);
        write_gain(REG_D_GAIN, 16'sd0);
        write_gain(REG_I_GAIN, 16'sd256);
        push_cmd(OP_SET,  SIDE_RIGHT, INTEG_LIMIT, 0);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, 0);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, 0);
        push_cmd(OP_SET,  SIDE_LEFT, -INTEG_LIMIT, 0);
        push_cmd(OP_TICK, SIDE_LEFT, 0, 0);
        push_cmd(OP_TICK, SIDE_LEFT, 0, 0);
        push_cmd(OP_SET,  SIDE_RIGHT, 0, 0);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, -3);
        wait_idle();
        // A write to the unused index must keep the accumulated integral, so
        // the next ticks carry on from where the loop was.
        write_gain(REG_NONE, 16'hFFFF);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, -3);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, -3);
        push_cmd(OP_TICK, SIDE_RIGHT, 0, -3);
        wait_idle();

        // Random phases, each under fresh gains. The last one runs without any
        // idling on either side.
        for (int ph = 0; ph < 4; ph++) begin
            write_gain(REG_P_GAIN, rand_gain());
            write_gain(REG_D_GAIN, rand_gain());
            write_gain(REG_I_GAIN, rand_gain());
            if ($urandom_range(0, 1))
                write_gain(REG_NONE, 16'($urandom));
            if (ph == 3)
                idle_en = 1'b0;
            push_random(50);
            // In one phase the sender holds off mid-stream until every
            // outstanding drive has come back.
            if (ph == 1)
                wait_idle();
            push_random(50);
            wait_idle();
        end

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/dmsp_pkg.sv
sv/dmsp_state.sv
sv/dmsp_law.sv
sv/dual_motor_speed_pid.sv
sv/dmsp_checker.sv
tb/tb_top.sv
